### rtl/core/swbb_pkg.sv
// swbb_pkg: shared types, codes and sizes for the sector write-back buffer
// no dependencies
package swbb_pkg;
   localparam int SectorBytes = 512;
   localparam int SectorWords = SectorBytes / 8;
   localparam int WordIdxW    = $clog2(SectorWords);
   localparam int OffW        = $clog2(SectorBytes);
   localparam int LocW        = 57;
   localparam int TagW        = 48;
   localparam int AbsW        = 49;
   localparam int QDepth      = 2;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_FILL  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      KIND_READ   = 3'd0,
      KIND_WDONE  = 3'd1,
      KIND_WBACK  = 3'd2,
      KIND_FETCH  = 3'd3,
      KIND_REJECT = 3'd4
   } kind_type;

   // operations handed from front to back
   typedef enum logic [2:0] {
      OP_HIT_RD,
      OP_HIT_WR,
      OP_FILL,
      OP_REJECT,
      OP_MISS
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               is_write;
      logic               do_wback;
      logic [OffW-1:0]    off;
      logic [7:0]         pay;
      logic [63:0]        fill;
      logic [WordIdxW-1:0] fidx;
      logic               flast;
      logic [AbsW-1:0]    wsec;
      logic [AbsW-1:0]    fsec;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RDWAIT,
      BK_WRWAIT,
      BK_WBACK
   } back_state_type;
endpackage

### rtl/core/swbb_ram.sv
// swbb_ram: generic single-port-write, one-read RAM with registered read
// depends on nothing
module swbb_ram #(
   parameter int Width = 64,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

### rtl/core/swbb_front.sv
// swbb_front: accepts requests, keeps tag/valid/dirty/fill state, classifies
// depends on swbb_pkg
module swbb_front import swbb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  logic [1:0]      action,
   input  logic [LocW-1:0] location,
   input  logic [7:0]      payload,
   input  logic [63:0]     fill_word,
   input  logic [TagW-1:0] part_start,
   output logic            cmd_valid,
   output cmd_type         cmd
);
   logic [TagW-1:0]   tag_ff, tag_in;
   logic              valid_ff, valid_in, dirty_ff, dirty_in, pend_ff, pend_in;
   logic [WordIdxW:0] cnt_ff, cnt_in;
   logic              hact_ff, hact_in;
   logic [OffW-1:0]   hoff_ff, hoff_in;
   logic [7:0]        hpay_ff, hpay_in;
   logic [TagW-1:0]   sect;
   logic [OffW-1:0]   off;

   assign sect = location[LocW-1 -: TagW];
   assign off  = location[OffW-1:0];

   always_comb begin
      tag_in = tag_ff; valid_in = valid_ff; dirty_in = dirty_ff; pend_in = pend_ff;
      cnt_in = cnt_ff; hact_in = hact_ff; hoff_in = hoff_ff; hpay_in = hpay_ff;
      cmd_valid = 1'b0;
      cmd = '0;
      cmd.op = OP_REJECT;
      cmd.off = off;
      cmd.pay = payload;
      cmd.fill = fill_word;
      cmd.fidx = cnt_ff[WordIdxW-1:0];
      cmd.wsec = AbsW'(part_start) + AbsW'(tag_ff);
      cmd.fsec = AbsW'(part_start) + AbsW'(sect);
      if (take) begin
         case (action_type'(action))
            ACT_FILL: begin
               if (pend_ff) begin
                  cmd_valid = 1'b1;
                  cmd.op = OP_FILL;
                  cmd.is_write = hact_ff;
                  cmd.off = hoff_ff;
                  cmd.pay = hpay_ff;
                  cmd.flast = (cnt_ff == (WordIdxW+1)'(SectorWords - 1));
                  cnt_in = cnt_ff + 1'b1;
                  if (cmd.flast) begin
                     pend_in = 1'b0; cnt_in = '0; valid_in = 1'b1;
                     dirty_in = hact_ff;
                  end
               end
            end
            ACT_READ, ACT_WRITE: begin
               cmd_valid = 1'b1;
               cmd.is_write = action[0];
               if (pend_ff) begin
                  cmd.op = OP_REJECT;
               end else if (valid_ff && sect == tag_ff) begin
                  cmd.op = action[0] ? OP_HIT_WR : OP_HIT_RD;
                  if (action[0]) dirty_in = 1'b1;
               end else begin
                  cmd.op = OP_MISS;
                  cmd.do_wback = valid_ff && dirty_ff;
                  tag_in = sect; valid_in = 1'b0; dirty_in = 1'b0; pend_in = 1'b1;
                  cnt_in = '0; hact_in = action[0]; hoff_in = off; hpay_in = payload;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0; valid_ff <= 1'b0; dirty_ff <= 1'b0; pend_ff <= 1'b0;
         cnt_ff <= '0; hact_ff <= 1'b0; hoff_ff <= '0; hpay_ff <= '0;
      end else begin
         tag_ff <= tag_in; valid_ff <= valid_in; dirty_ff <= dirty_in; pend_ff <= pend_in;
         cnt_ff <= cnt_in; hact_ff <= hact_in; hoff_ff <= hoff_in; hpay_ff <= hpay_in;
      end
   end
endmodule

### rtl/core/swbb_queue.sv
// swbb_queue: short command fifo between front and back
// depends on swbb_pkg
module swbb_queue import swbb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output logic    not_empty,
   output logic    full,
   output cmd_type head
);
   localparam int PtrW = $clog2(QDepth);
   cmd_type           slot_ff [QDepth];
   logic [PtrW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [PtrW:0]     cnt_ff, cnt_in;

   assign not_empty = cnt_ff != '0;
   assign full      = cnt_ff == (PtrW+1)'(QDepth);
   assign head      = slot_ff[rp_ff];

   always_comb begin
      wp_in = push ? PtrW'((32'(wp_ff) + 1) % QDepth) : wp_ff;
      rp_in = pop  ? PtrW'((32'(rp_ff) + 1) % QDepth) : rp_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule

### rtl/core/swbb_back.sv
// swbb_back: carries out queued commands on the sector RAM, emits results
// depends on swbb_pkg, swbb_ram
module swbb_back import swbb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  cmd_type             q_head,
   output logic                q_pop,
   output logic                out_strobe,
   output logic [2:0]          out_kind,
   output logic [63:0]         out_data,
   output logic [WordIdxW-1:0] out_index,
   output logic [AbsW-1:0]     out_wsec,
   output logic                out_freq,
   output logic [AbsW-1:0]     out_fsec,
   output logic                out_last
);
   back_state_type      st_ff, st_in;
   logic [WordIdxW-1:0] wi_ff, wi_in;
   cmd_type             cur_ff, cur_in;
   logic                wr_en;
   logic [WordIdxW-1:0] wr_addr, rd_addr;
   logic [63:0]         wr_data, rd_data, rd_word;
   logic [5:0]          sh, sh_cur;

   swbb_ram #(.Width(64), .Depth(SectorWords)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   assign sh     = {q_head.off[2:0], 3'b000};
   assign sh_cur = {cur_ff.off[2:0], 3'b000};
   // a read held behind the last fill word takes that word from the command itself
   assign rd_word = (cur_ff.op == OP_FILL && cur_ff.off[OffW-1:3] == cur_ff.fidx) ?
                    cur_ff.fill : rd_data;

   // next state
   always_comb begin
      st_in = st_ff; wi_in = wi_ff; cur_in = cur_ff;
      case (st_ff)
         BK_IDLE: begin
            if (q_valid) begin
               cur_in = q_head;
               case (q_head.op)
                  OP_HIT_RD: st_in = BK_RDWAIT;
                  OP_HIT_WR: st_in = BK_WRWAIT;
                  OP_FILL:   if (q_head.flast && !q_head.is_write) st_in = BK_RDWAIT;
                  OP_MISS:   if (q_head.do_wback) begin st_in = BK_WBACK; wi_in = '0; end
                  default: ;
               endcase
            end
         end
         BK_RDWAIT: st_in = BK_IDLE;
         BK_WRWAIT: st_in = BK_IDLE;
         BK_WBACK: begin
            wi_in = wi_ff + 1'b1;
            if (wi_ff == WordIdxW'(SectorWords - 1)) st_in = BK_IDLE;
         end
         default: st_in = BK_IDLE;
      endcase
   end

   // outputs and RAM control
   always_comb begin
      q_pop = 1'b0; wr_en = 1'b0; wr_addr = q_head.off[OffW-1:3]; wr_data = q_head.fill;
      rd_addr = q_head.off[OffW-1:3];
      out_strobe = 1'b0; out_kind = KIND_READ; out_data = '0; out_index = '0;
      out_wsec = '0; out_freq = 1'b0; out_fsec = '0; out_last = 1'b0;
      case (st_ff)
         BK_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               case (q_head.op)
                  OP_FILL: begin
                     wr_en = 1'b1; wr_addr = q_head.fidx;
                     // a held write merges its byte as its own word arrives
                     if (q_head.is_write && q_head.off[OffW-1:3] == q_head.fidx) begin
                        wr_data = (q_head.fill & ~(64'hFF << sh)) |
                                  (64'(q_head.pay) << sh);
                     end
                     if (q_head.flast && q_head.is_write) begin
                        out_strobe = 1'b1; out_kind = KIND_WDONE; out_last = 1'b1;
                     end
                  end
                  OP_REJECT: begin
                     out_strobe = 1'b1; out_kind = KIND_REJECT; out_last = 1'b1;
                  end
                  OP_MISS: begin
                     rd_addr = '0;
                     if (!q_head.do_wback) begin
                        out_strobe = 1'b1; out_kind = KIND_FETCH; out_freq = 1'b1;
                        out_fsec = q_head.fsec; out_last = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_RDWAIT: begin
            out_strobe = 1'b1; out_kind = KIND_READ; out_last = 1'b1;
            out_data = {56'd0, 8'(rd_word >> sh_cur)};
         end
         BK_WRWAIT: begin
            // old word read last cycle, write it back with the new byte
            wr_en = 1'b1; wr_addr = cur_ff.off[OffW-1:3];
            wr_data = (rd_data & ~(64'hFF << sh_cur)) | (64'(cur_ff.pay) << sh_cur);
            out_strobe = 1'b1; out_kind = KIND_WDONE; out_last = 1'b1;
         end
         BK_WBACK: begin
            rd_addr = wi_ff + 1'b1;
            out_strobe = 1'b1; out_kind = KIND_WBACK; out_data = rd_data;
            out_index = wi_ff; out_wsec = cur_ff.wsec;
            if (wi_ff == WordIdxW'(SectorWords - 1)) begin
               out_freq = 1'b1; out_fsec = cur_ff.fsec; out_last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      wi_ff  <= wi_in;
      if (reset) st_ff <= BK_IDLE;
      else       st_ff <= st_in;
   end
endmodule

### rtl/core/sector_write_back_buffer.sv
// sector_write_back_buffer: top level of the single-line sector cache
// depends on swbb_pkg, swbb_front, swbb_queue, swbb_back
//
//  channel | ports                      | handshake
//  req     | req_action .. req_fill_word| start & !busy
//  rsp     | rsp_kind .. rsp_last       | rsp_strobe, one cycle, no stall
//  csr     | csr_data                   | csr_valid & csr_ready
//
// the front takes one request a cycle while the two-entry queue has room.
// in the back a fill word, reject or clean miss is handled straight from idle;
// a hit read, hit write or held read on the last fill word goes through a
// wait state (registered RAM read, then result or merged write back); a dirty
// miss reads word 0, then sends the 64 write-back words. busy is high while
// the command queue is full. reset clears tag, flags, counters and queue; the
// sector RAM holds garbage until filled. results cannot be stalled.
module sector_write_back_buffer import swbb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [1:0]      req_action,
   input  logic [LocW-1:0] req_location,
   input  logic [7:0]      req_payload,
   input  logic [63:0]     req_fill_word,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [TagW-1:0] csr_data,
   output logic            rsp_strobe,
   output logic [2:0]      rsp_kind,
   output logic [63:0]     rsp_data,
   output logic [5:0]      rsp_word_index,
   output logic [AbsW-1:0] rsp_writeback_sector,
   output logic            rsp_fetch_request,
   output logic [AbsW-1:0] rsp_fetch_sector,
   output logic            rsp_last
);
   logic [TagW-1:0] pstart_ff;
   logic            take, push, pop, ne, full;
   cmd_type         pcmd, head;

   assign csr_ready = 1'b1;
   // requests wait while the command queue is full
   assign busy = full;
   assign take = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) pstart_ff <= '0;
      else if (csr_valid) pstart_ff <= csr_data;
   end

   swbb_front u_front (
      .clock, .reset, .take, .action(req_action), .location(req_location),
      .payload(req_payload), .fill_word(req_fill_word), .part_start(pstart_ff),
      .cmd_valid(push), .cmd(pcmd)
   );

   swbb_queue u_queue (
      .clock, .reset, .push, .push_data(pcmd), .pop, .not_empty(ne), .full, .head
   );

   swbb_back u_back (
      .clock, .reset, .q_valid(ne), .q_head(head), .q_pop(pop),
      .out_strobe(rsp_strobe), .out_kind(rsp_kind), .out_data(rsp_data),
      .out_index(rsp_word_index), .out_wsec(rsp_writeback_sector),
      .out_freq(rsp_fetch_request), .out_fsec(rsp_fetch_sector), .out_last(rsp_last)
   );
endmodule

### verif/swbb_checker.sv
// swbb_checker: watches the request, configuration and result channels of the
// sector write-back buffer, predicts every result and compares them in order
// depends on swbb_pkg
module swbb_checker import swbb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            busy,
   input  logic [1:0]      req_action,
   input  logic [LocW-1:0] req_location,
   input  logic [7:0]      req_payload,
   input  logic [63:0]     req_fill_word,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic [TagW-1:0] csr_data,
   input  logic            rsp_strobe,
   input  logic [2:0]      rsp_kind,
   input  logic [63:0]     rsp_data,
   input  logic [5:0]      rsp_word_index,
   input  logic [AbsW-1:0] rsp_writeback_sector,
   input  logic            rsp_fetch_request,
   input  logic [AbsW-1:0] rsp_fetch_sector,
   input  logic            rsp_last,
   output int              failures,
   output int              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0]      kind;
      logic [63:0]     data;
      logic [5:0]      widx;
      logic [AbsW-1:0] wsec;
      logic            freq;
      logic [AbsW-1:0] fsec;
      logic            last;
   } sector_result_t;

   sector_result_t  due_results[$];
   logic [63:0]     line_words[SectorWords];
   logic [TagW-1:0] part_base;
   logic [TagW-1:0] line_tag;
   logic            line_valid, line_dirty, filling;
   int              fill_pos;
   logic [1:0]      hold_act;
   logic [OffW-1:0] hold_off;
   logic [7:0]      hold_pay;

   initial begin
      failures = 0;
      outstanding = 0;
   end

   task automatic push_result(logic [2:0] kind, logic [63:0] data, logic [5:0] widx,
                              logic [AbsW-1:0] wsec, logic freq, logic [AbsW-1:0] fsec,
                              logic last);
      sector_result_t r;
      r.kind = kind; r.data = data; r.widx = widx; r.wsec = wsec;
      r.freq = freq; r.fsec = fsec; r.last = last;
      due_results.push_back(r);
   endtask

   task automatic finish_access(logic [1:0] act, logic [OffW-1:0] off, logic [7:0] pay);
      if (act == ACT_READ) begin
         push_result(KIND_READ, {56'd0, line_words[off[OffW-1:3]][off[2:0]*8 +: 8]},
                     '0, '0, 1'b0, '0, 1'b1);
      end else begin
         line_words[off[OffW-1:3]][off[2:0]*8 +: 8] = pay;
         line_dirty = 1'b1;
         push_result(KIND_WDONE, '0, '0, '0, 1'b0, '0, 1'b1);
      end
   endtask

   task automatic predict_request(logic [1:0] act, logic [LocW-1:0] loc, logic [7:0] pay,
                                  logic [63:0] fw);
      logic [TagW-1:0] sect;
      logic [AbsW-1:0] fsec, wsec;
      sect = loc[LocW-1:OffW];
      if (act == ACT_FILL) begin
         if (filling) begin
            line_words[fill_pos] = fw;
            fill_pos++;
            if (fill_pos == SectorWords) begin
               filling = 1'b0;
               fill_pos = 0;
               line_valid = 1'b1;
               line_dirty = 1'b0;
               finish_access(hold_act, hold_off, hold_pay);
            end
         end
      end else if (act != ACT_NONE) begin
         if (filling) begin
            push_result(KIND_REJECT, '0, '0, '0, 1'b0, '0, 1'b1);
         end else if (line_valid && sect == line_tag) begin
            finish_access(act, loc[OffW-1:0], pay);
         end else begin
            fsec = AbsW'(part_base) + AbsW'(sect);
            wsec = AbsW'(part_base) + AbsW'(line_tag);
            if (line_valid && line_dirty) begin
               for (int i = 0; i < SectorWords; i++) begin
                  if (i == SectorWords - 1)
                     push_result(KIND_WBACK, line_words[i], 6'(i), wsec, 1'b1, fsec, 1'b1);
                  else
                     push_result(KIND_WBACK, line_words[i], 6'(i), wsec, 1'b0, '0, 1'b0);
               end
            end else begin
               push_result(KIND_FETCH, '0, '0, '0, 1'b1, fsec, 1'b1);
            end
            line_tag = sect;
            line_valid = 1'b0;
            line_dirty = 1'b0;
            filling = 1'b1;
            fill_pos = 0;
            hold_act = act;
            hold_off = loc[OffW-1:0];
            hold_pay = pay;
         end
      end
   endtask

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h actual %h", name, exp_v, act_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      sector_result_t e;
      if (reset) begin
         due_results.delete();
         part_base = '0;
         line_tag = '0;
         line_valid = 1'b0;
         line_dirty = 1'b0;
         filling = 1'b0;
         fill_pos = 0;
         hold_act = ACT_READ;
         hold_off = '0;
         hold_pay = '0;
      end else begin
         if (rsp_strobe) begin
            if (due_results.size() == 0) begin
               $error("result with nothing expected: kind %0d", rsp_kind);
               failures++;
            end else begin
               e = due_results.pop_front();
               check_field("kind", 64'(e.kind), 64'(rsp_kind));
               check_field("data", e.data, rsp_data);
               check_field("word_index", 64'(e.widx), 64'(rsp_word_index));
               check_field("writeback_sector", 64'(e.wsec), 64'(rsp_writeback_sector));
               check_field("fetch_request", 64'(e.freq), 64'(rsp_fetch_request));
               check_field("fetch_sector", 64'(e.fsec), 64'(rsp_fetch_sector));
               check_field("last", 64'(e.last), 64'(rsp_last));
            end
         end
         if (csr_valid && csr_ready) part_base = csr_data;
         if (start && !busy) predict_request(req_action, req_location, req_payload,
                                             req_fill_word);
      end
      outstanding = due_results.size();
   end
endmodule

### verif/sector_write_back_buffer_test.sv
// sector_write_back_buffer_test: drives requests and partition settings into the
// sector write-back buffer and gives the verdict from the checker's counts
// depends on swbb_pkg, swbb_checker and the block
module sector_write_back_buffer_test;
   import swbb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   logic [1:0]      req_action = ACT_NONE;
   logic [LocW-1:0] req_location = '0;
   logic [7:0]      req_payload = '0;
   logic [63:0]     req_fill_word = '0;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [TagW-1:0] csr_data = '0;
   logic            rsp_strobe;
   logic [2:0]      rsp_kind;
   logic [63:0]     rsp_data;
   logic [5:0]      rsp_word_index;
   logic [AbsW-1:0] rsp_writeback_sector;
   logic            rsp_fetch_request;
   logic [AbsW-1:0] rsp_fetch_sector;
   logic            rsp_last;
   int              failures, outstanding;

   // stimulus-side view of which sector the buffer holds, to steer hits and fills
   logic [TagW-1:0] cur_sector = '0;
   logic            cur_valid = 1'b0;
   int              burst_left = 0;

   sector_write_back_buffer i_dut (.*);

   swbb_checker i_checker (.*);

   always #5 clock = ~clock;

   initial begin
      #3ms;
      $display("sector_write_back_buffer_test NOT OK");
      $finish;
   end

   // one request; start stays high across a burst, gaps drop it
   task automatic issue(logic [1:0] act, logic [LocW-1:0] loc, logic [7:0] pay,
                        logic [63:0] fw);
      logic taken;
      start         <= 1'b1;
      req_action    <= act;
      req_location  <= loc;
      req_payload   <= pay;
      req_fill_word <= fw;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // the 64 fill words of a pending miss, with rejects and ignored noise mixed in
   task automatic feed_fill(logic [TagW-1:0] sect);
      repeat ($urandom_range(0, 2))
         issue(2'($urandom_range(0, 1)), LocW'({$urandom, $urandom}), 8'($urandom),
               rand_word());
      for (int i = 0; i < SectorWords; i++) begin
         if ($urandom_range(0, 15) == 0) issue(ACT_NONE, '0, '0, rand_word());
         issue(ACT_FILL, LocW'({$urandom, $urandom}), 8'($urandom), rand_word());
      end
      cur_sector = sect;
      cur_valid  = 1'b1;
   endtask

   // read or write; a miss is followed by its fill
   task automatic access(logic [1:0] act, logic [LocW-1:0] loc, logic [7:0] pay);
      issue(act, loc, pay, {$urandom, $urandom});
      if (!(cur_valid && cur_sector == loc[LocW-1:OffW])) feed_fill(loc[LocW-1:OffW]);
   endtask

   // random byte within the held sector
   function automatic logic [LocW-1:0] pick_location();
      return {cur_sector, OffW'($urandom)};
   endfunction

   // settings only change with nothing in flight
   task automatic set_partition(logic [TagW-1:0] base);
      logic taken;
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= base;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [TagW-1:0] bases[4];
      int              hang;
      bases = '{'1, TagW'(1), TagW'({$urandom, $urandom}), '0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stray fill word and idle action, cold read miss in the last word,
      // hits at the edges
      issue(ACT_FILL, '0, '0, '1);
      issue(ACT_NONE, '1, '1, '1);
      access(ACT_READ, LocW'(505), 8'h00);
      access(ACT_WRITE, LocW'(0), 8'hFF);
      access(ACT_WRITE, LocW'(511), 8'h00);
      access(ACT_WRITE, LocW'(511), 8'hA5);
      access(ACT_READ, LocW'(0), 8'h00);
      access(ACT_READ, LocW'(511), 8'hFF);
      // dirty write miss into the top sector with a large partition base
      set_partition('1);
      access(ACT_WRITE, {{TagW{1'b1}}, OffW'(77)}, 8'h5A);
      access(ACT_READ, {{TagW{1'b1}}, OffW'(77)}, 8'h00);
      access(ACT_READ, '1, 8'h00);
      access(ACT_WRITE, '1, 8'hFF);
      issue(ACT_FILL, '0, '0, '0);

      // random phases, each under its own partition base, on the held sector
      foreach (bases[p]) begin
         set_partition(bases[p]);
         repeat (5) begin
            if ($urandom_range(0, 4) == 0)
               issue(2'($urandom_range(2, 3)), LocW'({$urandom, $urandom}), 8'($urandom),
                     rand_word());
            access(2'($urandom_range(0, 1)), pick_location(), 8'($urandom));
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(negedge clock);
      hang = 0;
      while (!rsp_strobe && hang < 40) begin
         @(negedge clock);
         hang++;
      end
      @(posedge clock);
      @(negedge clock);
      if (failures == 0 && outstanding == 0)
         $display("sector_write_back_buffer_test OK");
      else
         $display("sector_write_back_buffer_test NOT OK");
      $finish;
   end
endmodule
